// ----- src/gdc_pkg.sv -----
package gdc_pkg;

  // field widths
  localparam int OP_W      = 3;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int IN_YEAR_W = 12;
  localparam int COUNT_W   = 16;
  localparam int DIST_W    = 21;

  // operation codes
  localparam logic [OP_W-1:0] OP_SET      = 3'd0;
  localparam logic [OP_W-1:0] OP_NEXT     = 3'd1;
  localparam logic [OP_W-1:0] OP_PREV     = 3'd2;
  localparam logic [OP_W-1:0] OP_ADVANCE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DISTANCE = 3'd4;

  // calendar constants
  localparam logic [MONTH_W-1:0]   MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0]   MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0]   MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]     DAY_FIRST = 5'd1;
  localparam logic [IN_YEAR_W-1:0] SET_YEAR_MIN = 12'd1900;
  localparam logic [IN_YEAR_W-1:0] SET_YEAR_MAX = 12'd2050;

  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // day number arithmetic: year extended by 4800/4900, one 17x18 multiplier
  localparam int Y_EXT_W     = 17;
  localparam int MUL_B_W     = 18;
  localparam int PROD_W      = Y_EXT_W + MUL_B_W;
  localparam int ACC_W       = 27;
  localparam int RECIP_SHIFT = 24;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int OFFSET_W    = 9;

  localparam logic [Y_EXT_W-1:0] YEAR_OFFSET_1 = 17'd4800;
  localparam logic [Y_EXT_W-1:0] YEAR_OFFSET_2 = 17'd4900;
  localparam logic [MUL_B_W-1:0] DAYS_PER_4Y   = 18'd1461;
  // ceil(2^24 / 100), exact quotient for values below about 199000
  localparam logic [MUL_B_W-1:0] RECIP_100     = 18'd167773;

  // (367 * shifted month) / 12, months counted from march
  localparam logic [OFFSET_W-1:0] MONTH_OFFSET [16] = '{
    9'd305, 9'd336, 9'd367, 9'd30,  9'd61,  9'd91,  9'd122, 9'd152,
    9'd183, 9'd214, 9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397
  };

  typedef struct packed {
    logic held;
    logic year_chg;
  } step_status_t;

  // month length, invalid months read as january
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    if (m < MONTH_JAN || m > MONTH_DEC) begin
      len = MONTH_DAYS[0];
    end else begin
      len = MONTH_DAYS[m - MONTH_JAN];
    end
    if (m == MONTH_FEB && leap) begin
      len = len + 1'b1;
    end
    return len;
  endfunction

endpackage

// ----- src/gdc_step.sv -----
module gdc_step import gdc_pkg::*; #(
  parameter int YEAR_BITS = 12
) (
  input  logic [DAY_W-1:0]     day,
  input  logic [MONTH_W-1:0]   month,
  input  logic [YEAR_BITS-1:0] year,
  input  logic                 leap,
  input  logic                 back,
  output logic [DAY_W-1:0]     new_day,
  output logic [MONTH_W-1:0]   new_month,
  output logic [YEAR_BITS-1:0] new_year,
  output step_status_t         status
);

  logic [DAY_W-1:0]   len;
  logic [MONTH_W-1:0] prev_month;

  assign len        = month_days(month, leap);
  assign prev_month = month - 1'b1;

  // one day forward or back, holding at the year limits
  always_comb begin
    new_day         = day;
    new_month       = month;
    new_year        = year;
    status.held     = 1'b0;
    status.year_chg = 1'b0;
    if (!back) begin
      if (day >= len) begin
        if (month >= MONTH_DEC) begin
          if (year == {YEAR_BITS{1'b1}}) begin
            status.held = 1'b1;
          end else begin
            new_year        = year + 1'b1;
            new_month       = MONTH_JAN;
            new_day         = DAY_FIRST;
            status.year_chg = 1'b1;
          end
        end else begin
          new_month = month + 1'b1;
          new_day   = DAY_FIRST;
        end
      end else begin
        new_day = day + 1'b1;
      end
    end else begin
      if (day <= DAY_FIRST) begin
        if (month <= MONTH_JAN) begin
          if (year == '0) begin
            status.held = 1'b1;
          end else begin
            // december has 31 days whatever the year
            new_year        = year - 1'b1;
            new_month       = MONTH_DEC;
            new_day         = month_days(MONTH_DEC, 1'b0);
            status.year_chg = 1'b1;
          end
        end else begin
          new_month = prev_month;
          new_day   = month_days(prev_month, leap);
        end
      end else begin
        new_day = day - 1'b1;
      end
    end
  end

endmodule

// ----- src/gregorian_date_counter.sv -----
// next and previous step the date once, recomputing the leap flag on a year change;
// set recomputes it on the shared multiplier; distance runs four products through
// the one multiplier; advance steps count days, recomputing the leap flag for each
// year crossed, a zero count going straight to the result. one transaction at a time;
// a new one waits for the registered result. reset loads 1 january 1900, no sweep.
module gregorian_date_counter import gdc_pkg::*; #(
  parameter int COUNT_BITS = 16,
  parameter int YEAR_BITS  = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [DAY_W-1:0]     in_day,
  input  logic [MONTH_W-1:0]   in_month,
  input  logic [IN_YEAR_W-1:0] in_year,
  input  logic [COUNT_W-1:0]   day_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DAY_W-1:0]     out_day,
  output logic [MONTH_W-1:0]   out_month,
  output logic [IN_YEAR_W-1:0] out_year,
  output logic [DIST_W-1:0]    distance
);

  localparam int CW = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;

  // distance sequence steps
  localparam logic [2:0] DS_T1_A = 3'd0;
  localparam logic [2:0] DS_Q_A  = 3'd1;
  localparam logic [2:0] DS_T1_B = 3'd2;
  localparam logic [2:0] DS_Q_B  = 3'd3;
  localparam logic [2:0] DS_LAST = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_LEAP_MUL, S_LEAP_EVAL, S_DIST, S_FIN
  } state_t;

  state_t               state;
  logic [DAY_W-1:0]     cur_day;
  logic [MONTH_W-1:0]   cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic                 leap;
  logic [CW-1:0]        cnt;
  logic                 back;
  logic                 is_dist;
  logic [Y_EXT_W-1:0]   b_y1;
  logic [Y_EXT_W-1:0]   b_y2;
  logic [2:0]           dstep;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     acc;

  logic [DAY_W-1:0]     step_day;
  logic [MONTH_W-1:0]   step_month;
  logic [YEAR_BITS-1:0] step_year;
  step_status_t         step_st;

  logic [Y_EXT_W-1:0]   cur_ext, a_y1, a_y2, in_ext, in_y1, in_y2;
  logic                 a_adj, in_adj;
  logic [Y_EXT_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_out;
  logic [ACC_W-1:0]     t1, t3, acc_next, acc_init, dist_abs;
  logic [Q_W+1:0]       q3;
  logic                 div100, leap_calc;
  logic [CW-1:0]        adv_cnt;

  gdc_step #(.YEAR_BITS(YEAR_BITS)) u_step (
    .day       (cur_day),
    .month     (cur_month),
    .year      (cur_year),
    .leap      (leap),
    .back      (back),
    .new_day   (step_day),
    .new_month (step_month),
    .new_year  (step_year),
    .status    (step_st)
  );

  assign in_ready = (state == S_IDLE);
  assign adv_cnt  = day_count[CW-1:0];

  // year terms with the march-based year shift
  assign cur_ext = Y_EXT_W'(cur_year);
  assign a_adj   = (cur_month <= MONTH_FEB);
  assign a_y1    = cur_ext + YEAR_OFFSET_1 - Y_EXT_W'(a_adj);
  assign a_y2    = cur_ext + YEAR_OFFSET_2 - Y_EXT_W'(a_adj);
  assign in_ext  = Y_EXT_W'(in_year);
  assign in_adj  = (in_month <= MONTH_FEB);
  assign in_y1   = in_ext + YEAR_OFFSET_1 - Y_EXT_W'(in_adj);
  assign in_y2   = in_ext + YEAR_OFFSET_2 - Y_EXT_W'(in_adj);

  // shared multiplier operand select
  always_comb begin
    mul_a = cur_ext;
    mul_b = RECIP_100;
    if (state == S_DIST) begin
      case (dstep)
        DS_T1_A: begin
          mul_a = a_y1;
          mul_b = DAYS_PER_4Y;
        end
        DS_Q_A: begin
          mul_a = a_y2;
          mul_b = RECIP_100;
        end
        DS_T1_B: begin
          mul_a = b_y1;
          mul_b = DAYS_PER_4Y;
        end
        DS_Q_B: begin
          mul_a = b_y2;
          mul_b = RECIP_100;
        end
        default: begin
          mul_a = cur_ext;
          mul_b = RECIP_100;
        end
      endcase
    end
  end

  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

  // terms taken from the registered product
  assign t1 = ACC_W'(prod >> 2);
  assign q3 = {prod[PROD_W-1:RECIP_SHIFT], 1'b0} + {1'b0, prod[PROD_W-1:RECIP_SHIFT]};
  assign t3 = ACC_W'(q3 >> 2);

  always_comb begin
    case (dstep)
      DS_Q_A:  acc_next = acc + t1;
      DS_T1_B: acc_next = acc - t3;
      DS_Q_B:  acc_next = acc - t1;
      DS_LAST: acc_next = acc + t3;
      default: acc_next = acc;
    endcase
  end

  // month offsets and days of both dates, the constant term cancels
  assign acc_init = ACC_W'(MONTH_OFFSET[cur_month]) + ACC_W'(cur_day)
                  - ACC_W'(MONTH_OFFSET[in_month]) - ACC_W'(in_day);
  assign dist_abs = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;

  // leap rule from the year times 1/100: a small fraction means a century
  assign div100    = (prod[RECIP_SHIFT-1:0] < RECIP_100[RECIP_SHIFT-1:0]);
  assign leap_calc = (cur_year[1:0] == 2'd0) &&
                     (!div100 || prod[RECIP_SHIFT+1:RECIP_SHIFT] == 2'd0);

  // sequencer, date state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_day   <= DAY_FIRST;
      cur_month <= MONTH_JAN;
      cur_year  <= YEAR_BITS'(SET_YEAR_MIN);
      leap      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the result register reloads in S_FIN, otherwise drains on acceptance
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_dist <= (operation == OP_DISTANCE);
            back    <= (operation == OP_PREV);
            case (operation)
              OP_SET: begin
                cur_day   <= (in_day >= DAY_FIRST) ? in_day : DAY_FIRST;
                cur_month <= (in_month >= MONTH_JAN && in_month <= MONTH_DEC) ?
                             in_month : MONTH_JAN;
                cur_year  <= (in_year >= SET_YEAR_MIN && in_year <= SET_YEAR_MAX) ?
                             YEAR_BITS'(in_year) : YEAR_BITS'(SET_YEAR_MIN);
                cnt       <= '0;
                state     <= S_LEAP_MUL;
              end
              OP_NEXT: begin
                cnt   <= CW'(1);
                state <= S_STEP;
              end
              OP_PREV: begin
                cnt   <= CW'(1);
                state <= S_STEP;
              end
              OP_ADVANCE: begin
                cnt   <= adv_cnt;
                state <= (adv_cnt == '0) ? S_FIN : S_STEP;
              end
              OP_DISTANCE: begin
                b_y1  <= in_y1;
                b_y2  <= in_y2;
                acc   <= acc_init;
                dstep <= DS_T1_A;
                state <= S_DIST;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_STEP: begin
          cnt <= cnt - 1'b1;
          if (step_st.held) begin
            state <= S_FIN;
          end else begin
            cur_day   <= step_day;
            cur_month <= step_month;
            cur_year  <= step_year;
            if (step_st.year_chg) begin
              state <= S_LEAP_MUL;
            end else if (cnt == CW'(1)) begin
              state <= S_FIN;
            end
          end
        end
        S_LEAP_MUL: begin
          prod  <= mul_out;
          state <= S_LEAP_EVAL;
        end
        S_LEAP_EVAL: begin
          leap  <= leap_calc;
          state <= (cnt != '0) ? S_STEP : S_FIN;
        end
        S_DIST: begin
          prod  <= mul_out;
          acc   <= acc_next;
          dstep <= dstep + 1'b1;
          if (dstep == DS_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_day   <= cur_day;
            out_month <= cur_month;
            out_year  <= cur_year[IN_YEAR_W-1:0];
            distance  <= is_dist ? dist_abs[DIST_W-1:0] : '0;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
